/* hw/rtl/pcp_pkg.sv */
// ----------------------------------------------------------------------------
// pcp_pkg: shared definitions for the point-in-convex-polygon block
// Fixed field widths and the control bundle that travels from the sequencer
// to the edge evaluation unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pcp_pkg;

    // Width of the vertex_count write data (cfg_wdata) and of the vertex_index field.
    localparam int CFG_W = 5;
    localparam int IDX_W = 4;

    // Request types carried in req_type.
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TEST = 1'b1;

    // Per-sample control for the edge unit.
    typedef struct packed {
        logic chk;   // pair this sample with the previous kept one and test the edge
        logic keep;  // this sample becomes the previous vertex for later edges
    } pcp_ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/pcp_cell.sv */
// ----------------------------------------------------------------------------
// pcp_cell: one vertex cell of the rotating vertex ring
// Holds one vertex. It is written directly by a vertex load and, during a
// test, takes the vertex of its neighbor on every shift.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcp_cell #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                         clk,
    input  wire logic                         load_en,
    input  wire logic                         shift_en,
    input  wire logic signed [COORD_BITS-1:0] load_x,
    input  wire logic signed [COORD_BITS-1:0] load_y,
    input  wire logic signed [COORD_BITS-1:0] nbr_x,
    input  wire logic signed [COORD_BITS-1:0] nbr_y,
    output logic signed [COORD_BITS-1:0]      vx,
    output logic signed [COORD_BITS-1:0]      vy
);

    logic signed [COORD_BITS-1:0] vx_reg;
    logic signed [COORD_BITS-1:0] vy_reg;
    logic signed [COORD_BITS-1:0] vx_next;
    logic signed [COORD_BITS-1:0] vy_next;

    always_comb
    begin
        vx_next = vx_reg;
        vy_next = vy_reg;
        if (load_en)
        begin
            vx_next = load_x;
            vy_next = load_y;
        end
        else if (shift_en)
        begin
            vx_next = nbr_x;
            vy_next = nbr_y;
        end
    end

    always_ff @(posedge clk)
    begin
        vx_reg <= vx_next;
        vy_reg <= vy_next;
    end

    assign vx = vx_reg;
    assign vy = vy_reg;

endmodule

`default_nettype wire

/* hw/rtl/pcp_edge.sv */
// ----------------------------------------------------------------------------
// pcp_edge: edge cross product unit at the head of the vertex ring
// Forms the vertex-minus-point differences, multiplies them against the
// previous kept vertex and flags an edge whose cross product is positive.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcp_edge #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic signed [COORD_BITS-1:0] head_x,
    input  wire logic signed [COORD_BITS-1:0] head_y,
    input  wire logic signed [COORD_BITS-1:0] pt_x,
    input  wire logic signed [COORD_BITS-1:0] pt_y,
    input  wire pcp_pkg::pcp_ctl_t            ctl,
    output logic                              edge_pos
);

    import pcp_pkg::*;

    localparam int D_W = COORD_BITS + 1;
    localparam int P_W = 2 * D_W;

    logic signed [D_W-1:0] dx;
    logic signed [D_W-1:0] dy;

    logic signed [D_W-1:0] cur_dx_reg;
    logic signed [D_W-1:0] cur_dy_reg;
    logic signed [D_W-1:0] prev_dx_reg;
    logic signed [D_W-1:0] prev_dy_reg;
    logic                  s1_chk_reg;
    logic                  s1_keep_reg;

    logic signed [P_W-1:0] p_reg;
    logic signed [P_W-1:0] q_reg;
    logic signed [P_W-1:0] p_next;
    logic signed [P_W-1:0] q_next;
    logic                  s2_chk_reg;

    assign dx = $signed({head_x[COORD_BITS-1], head_x}) - $signed({pt_x[COORD_BITS-1], pt_x});
    assign dy = $signed({head_y[COORD_BITS-1], head_y}) - $signed({pt_y[COORD_BITS-1], pt_y});

    // Edge runs from the previous kept vertex to the current sample:
    // z = prev_dx * cur_dy - cur_dx * prev_dy, positive when p > q.
    assign p_next = prev_dx_reg * cur_dy_reg;
    assign q_next = cur_dx_reg * prev_dy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_chk_reg  <= 1'b0;
            s1_keep_reg <= 1'b0;
            s2_chk_reg  <= 1'b0;
        end
        else
        begin
            s1_chk_reg  <= ctl.chk;
            s1_keep_reg <= ctl.keep;
            s2_chk_reg  <= s1_chk_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_dx_reg <= dx;
        cur_dy_reg <= dy;
        if (s1_keep_reg)
        begin
            prev_dx_reg <= cur_dx_reg;
            prev_dy_reg <= cur_dy_reg;
        end
        p_reg <= p_next;
        q_reg <= q_next;
    end

    assign edge_pos = s2_chk_reg && (p_reg > q_reg);

endmodule

`default_nettype wire

/* hw/rtl/point_in_convex_polygon_top.sv */
// ----------------------------------------------------------------------------
// point_in_convex_polygon_top: convex polygon containment test
// Vertex ring of cells, edge cross product unit and test sequencer.
// ----------------------------------------------------------------------------
// A vertex load (req_type 0) gives no result. For a point test (req_type 1)
// the vertex ring rotates once through all MAX_VERTICES cells past the
// single cross product unit at its head, one vertex per cycle; the unit's
// two pipeline stages then drain, and the result enters the output register
// once it is free. A test reports inside_res = 1 when no edge cross product
// is positive, so points on an edge count as inside, and a vertex count of
// zero reports inside. The input takes a new transfer only while no test is
// running; a finished result waits in the output register while loads or
// the next test proceed. Loads with an index beyond MAX_VERTICES - 1 are
// dropped, and vertex_count writes above MAX_VERTICES saturate. Write
// vertex_count only while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module point_in_convex_polygon_top #(
    parameter int MAX_VERTICES = 16,
    parameter int COORD_BITS   = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [pcp_pkg::CFG_W-1:0]    cfg_wdata,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic                         req_type,
    input  wire logic [pcp_pkg::IDX_W-1:0]    vertex_index,
    input  wire logic signed [COORD_BITS-1:0] coord_x,
    input  wire logic signed [COORD_BITS-1:0] coord_y,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic                              inside_res
);

    import pcp_pkg::*;

    localparam int CNT_W = $clog2(MAX_VERTICES + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_RUN    = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [CNT_W-1:0]      step_reg;
    logic [CNT_W-1:0]      step_next;
    logic                  drain_reg;
    logic                  drain_next;
    logic                  inside_reg;
    logic                  inside_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  out_res_reg;
    logic                  out_res_next;
    logic signed [COORD_BITS-1:0] px_reg;
    logic signed [COORD_BITS-1:0] py_reg;

    logic                  in_xfer;
    logic                  load_xfer;
    logic                  test_xfer;
    logic                  out_xfer;
    logic                  shift_en;
    logic                  last_step;
    logic                  edge_pos;
    logic [31:0]           cfg_ext;
    logic [31:0]           idx_ext;
    pcp_ctl_t              ctl;

    logic signed [COORD_BITS-1:0] cell_x [MAX_VERTICES];
    logic signed [COORD_BITS-1:0] cell_y [MAX_VERTICES];

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign load_xfer = in_xfer && (req_type == REQ_LOAD);
    assign test_xfer = in_xfer && (req_type == REQ_TEST);
    assign out_xfer  = out_valid_reg && !out_stall;

    assign cfg_ext = 32'(cfg_wdata);
    assign idx_ext = 32'(vertex_index);

    assign last_step = (step_reg == CNT_W'(MAX_VERTICES));
    assign shift_en  = (state_reg == ST_RUN) && !last_step;

    // Sample k of a test is vertex k; after the full rotation vertex 0 is back
    // at the head and closes the polygon against the last vertex in use.
    always_comb
    begin
        ctl.chk  = 1'b0;
        ctl.keep = 1'b0;
        if (state_reg == ST_RUN)
        begin
            ctl.keep = (step_reg < count_reg);
            ctl.chk  = ((step_reg != '0) && (step_reg < count_reg))
                     || (last_step && (count_reg != '0));
        end
    end

    genvar k;
    generate
        for (k = 0; k < MAX_VERTICES; k++)
        begin : g_cell
            localparam int NB = (k + 1) % MAX_VERTICES;
            pcp_cell #(
                .COORD_BITS (COORD_BITS)
            ) u_cell (
                .clk      (clk),
                .load_en  (load_xfer && (idx_ext == 32'(k))),
                .shift_en (shift_en),
                .load_x   (coord_x),
                .load_y   (coord_y),
                .nbr_x    (cell_x[NB]),
                .nbr_y    (cell_y[NB]),
                .vx       (cell_x[k]),
                .vy       (cell_y[k])
            );
        end
    endgenerate

    pcp_edge #(
        .COORD_BITS (COORD_BITS)
    ) u_edge (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_x   (cell_x[0]),
        .head_y   (cell_y[0]),
        .pt_x     (px_reg),
        .pt_y     (py_reg),
        .ctl      (ctl),
        .edge_pos (edge_pos)
    );

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        drain_next     = drain_reg;
        inside_next    = inside_reg;
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        count_next     = count_reg;

        if (cfg_we)
        begin
            if (cfg_ext > 32'(MAX_VERTICES))
                count_next = CNT_W'(MAX_VERTICES);
            else
                count_next = CNT_W'(cfg_ext);
        end

        if (out_xfer)
            out_valid_next = 1'b0;

        if (edge_pos)
            inside_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (test_xfer)
                begin
                    state_next  = ST_RUN;
                    step_next   = '0;
                    inside_next = 1'b1;
                end
            end
            ST_RUN:
            begin
                if (last_step)
                begin
                    state_next = ST_DRAIN;
                    drain_next = 1'b0;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (drain_reg)
                    state_next = ST_FINISH;
                else
                    drain_next = 1'b1;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_res_next   = inside_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            drain_reg     <= 1'b0;
            inside_reg    <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            step_reg      <= step_next;
            drain_reg     <= drain_next;
            inside_reg    <= inside_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
        if (test_xfer)
        begin
            px_reg <= coord_x;
            py_reg <= coord_y;
        end
    end

    assign out_valid  = out_valid_reg;
    assign inside_res = out_res_reg;

endmodule

`default_nettype wire

/* test/point_in_convex_polygon_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_convex_polygon_top_tb: containment test bench
// Loads vertex tables, programs vertex_count between phases and probes points
// inside, on and around convex polygons. The expected inside flag is computed
// with exact integer cross products when each test transfer is accepted.
// ----------------------------------------------------------------------------

module point_in_convex_polygon_top_tb;

    import pcp_pkg::*;

    localparam int VERTS      = 16;
    localparam int CW         = 16;
    localparam int COORD_MAX  = 32767;
    localparam int COORD_MIN  = -32768;
    localparam int SETTLE     = VERTS + 8;
    localparam int LONG_HOLD  = 300;
    localparam int CYCLE_CAP  = 500000;
    localparam real TWO_PI    = 6.283185307179586;

    typedef struct {
        logic             req;
        logic [IDX_W-1:0] idx;
        int               x;
        int               y;
    } poly_req_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 req_type = REQ_LOAD;
    logic [IDX_W-1:0]     vertex_index = '0;
    logic signed [CW-1:0] coord_x = '0;
    logic signed [CW-1:0] coord_y = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 inside_res;

    point_in_convex_polygon_top #(
        .MAX_VERTICES(VERTS),
        .COORD_BITS  (CW)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .vertex_index(vertex_index),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .inside_res  (inside_res)
    );

    poly_req_t pending_requests[$];
    bit        expected_inside[$];

    // Shadow copy of the block's vertex tables and programmed count.
    int vert_x[VERTS];
    int vert_y[VERTS];
    int active_vertices = 0;

    int errors = 0;
    int cycle_count = 0;
    bit req_taken = 1'b0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit long_hold_on = 1'b0;
    int hold_count = 0;

    // Polygon currently intended by the stimulus.
    int poly_x[VERTS];
    int poly_y[VERTS];
    int poly_cx;
    int poly_cy;
    int poly_r;

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic int clamp_coord(input int v);
        if (v > COORD_MAX)
            return COORD_MAX;
        if (v < COORD_MIN)
            return COORD_MIN;
        return v;
    endfunction

    function automatic int spread(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic int any_coord();
        return int'($urandom_range(0, 65535)) + COORD_MIN;
    endfunction

    // A point is outside as soon as one edge has a positive cross product.
    function automatic bit polygon_contains(input int px, input int py);
        longint dx1, dy1, dx2, dy2;
        int     nxt;
        bit     hit;
        hit = 1'b1;
        for (int i = 0; i < active_vertices; i++)
        begin
            nxt = (i + 1 == active_vertices) ? 0 : i + 1;
            dx1 = longint'(vert_x[i]) - px;
            dy1 = longint'(vert_y[i]) - py;
            dx2 = longint'(vert_x[nxt]) - px;
            dy2 = longint'(vert_y[nxt]) - py;
            if (dx1 * dy2 - dx2 * dy1 > 0)
                hit = 1'b0;
        end
        return hit;
    endfunction

    task automatic queue_load(input int slot, input int x, input int y);
        poly_req_t r;
        r.req = REQ_LOAD;
        r.idx = slot[IDX_W-1:0];
        r.x   = x;
        r.y   = y;
        pending_requests = {pending_requests, r};
    endtask

    task automatic queue_test(input int x, input int y);
        poly_req_t r;
        r.req = REQ_TEST;
        r.idx = IDX_W'($urandom_range(0, VERTS - 1));
        r.x   = x;
        r.y   = y;
        pending_requests = {pending_requests, r};
    endtask

    // Vertices sit on a jittered circle; decreasing angles give a clockwise
    // ring, which is the orientation the block reports as inside.
    task automatic make_polygon(input int n, input bit clockwise);
        int  order[VERTS];
        int  k, pick, tmp, lim;
        real base, step, ang;
        if ($urandom_range(0, 3) == 0)
            poly_r = int'($urandom_range(16000, COORD_MAX));
        else
            poly_r = int'($urandom_range(8, 4000));
        lim = COORD_MAX - poly_r;
        poly_cx = spread(lim);
        poly_cy = spread(lim);
        step = TWO_PI / n;
        base = TWO_PI * $urandom_range(0, 999) / 1000.0;
        for (k = 0; k < n; k++)
        begin
            ang = k * step + step * 0.4 * $urandom_range(0, 999) / 1000.0;
            ang = clockwise ? base - ang : base + ang;
            poly_x[k] = clamp_coord(poly_cx + $rtoi(poly_r * $cos(ang)));
            poly_y[k] = clamp_coord(poly_cy + $rtoi(poly_r * $sin(ang)));
            order[k] = k;
        end
        for (k = n - 1; k > 0; k--)
        begin
            pick = $urandom_range(0, k);
            tmp = order[k];
            order[k] = order[pick];
            order[pick] = tmp;
        end
        for (k = 0; k < n; k++)
            queue_load(order[k], poly_x[order[k]], poly_y[order[k]]);
    endtask

    task automatic queue_probe(input int n);
        int kind, i, j, px, py;
        i = (n > 0) ? $urandom_range(0, n - 1) : 0;
        j = (i + 1 >= n) ? 0 : i + 1;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1:
            begin
                px = poly_cx + spread(poly_r / 4);
                py = poly_cy + spread(poly_r / 4);
            end
            2:
            begin
                px = poly_x[i];
                py = poly_y[i];
            end
            3:
            begin
                px = (poly_x[i] + poly_x[j]) / 2;
                py = (poly_y[i] + poly_y[j]) / 2;
            end
            4:
            begin
                px = poly_x[i] + spread(1);
                py = poly_y[i] + spread(1);
            end
            5:
            begin
                px = (poly_x[i] + poly_x[j]) / 2 + spread(1);
                py = (poly_y[i] + poly_y[j]) / 2 + spread(1);
            end
            6:
            begin
                px = any_coord();
                py = any_coord();
            end
            7:
            begin
                px = ($urandom_range(0, 1) == 0) ? COORD_MIN : COORD_MAX;
                py = ($urandom_range(0, 1) == 0) ? COORD_MIN : COORD_MAX;
            end
            default:
            begin
                px = poly_cx + spread(poly_r + poly_r / 4);
                py = poly_cy + spread(poly_r + poly_r / 4);
            end
        endcase
        queue_test(clamp_coord(px), clamp_coord(py));
    endtask

    task automatic program_vertex_count(input int c);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= c[CFG_W-1:0];
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // Loads give no result, so after the last result the block may still be
    // busy; the settle time covers one full pass of the vertex ring.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_requests.size() != 0 || in_valid || expected_inside.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    always @(negedge clk)
    begin : request_driver
        poly_req_t nxt;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || req_taken)
        begin
            if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                nxt = pending_requests.pop_front();
                req_type     <= nxt.req;
                vertex_index <= nxt.idx;
                coord_x      <= nxt.x[CW-1:0];
                coord_y      <= nxt.y[CW-1:0];
                in_valid     <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin : result_stall_ctl
        if (!rst_n)
            out_stall <= 1'b0;
        else if (long_hold_on && hold_count < LONG_HOLD)
        begin
            out_stall  <= 1'b1;
            hold_count <= hold_count + 1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Results are checked before the transfer of the same edge updates the
    // shadow tables, so the order within one edge is fixed.
    always @(posedge clk)
    begin : track_and_check
        bit want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_inside.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none actual %0b",
                             $time, inside_res);
                    errors++;
                end
                else
                begin
                    want = expected_inside.pop_front();
                    if (inside_res !== want)
                    begin
                        $display("%0t: inside_res mismatch, expected %0b actual %0b",
                                 $time, want, inside_res);
                        errors++;
                    end
                end
            end
            if (cfg_we)
                active_vertices = (cfg_wdata > VERTS) ? VERTS : int'(cfg_wdata);
            if (in_valid && !in_stall)
            begin
                if (req_type == REQ_LOAD)
                begin
                    vert_x[vertex_index] = coord_x;
                    vert_y[vertex_index] = coord_y;
                end
                else
                    expected_inside = {expected_inside,
                                       polygon_contains(coord_x, coord_y)};
            end
            req_taken <= in_valid && !in_stall;
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycle_count++;
        if (cycle_count == CYCLE_CAP)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin : stimulus
        int phase_counts[12];
        int eff, r, slot, mode;
        phase_counts = '{3, 16, 31, 2, 5, 20, 8, 16, 12, 3, 17, 6};

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill every slot first; a zero count must still report inside.
        program_vertex_count(0);
        make_polygon(VERTS, 1'b1);
        queue_test(COORD_MIN, COORD_MIN);
        queue_test(COORD_MAX, COORD_MAX);
        wait_drained();

        // A single vertex forms a degenerate edge.
        program_vertex_count(1);
        queue_test(12345, -23456);
        wait_drained();

        // Full-range square, clockwise then counterclockwise.
        program_vertex_count(4);
        queue_load(0, COORD_MIN, COORD_MAX);
        queue_load(1, COORD_MAX, COORD_MAX);
        queue_load(2, COORD_MAX, COORD_MIN);
        queue_load(3, COORD_MIN, COORD_MIN);
        queue_test(COORD_MIN, COORD_MIN);
        queue_test(0, COORD_MAX);
        queue_test(0, 0);
        queue_load(1, COORD_MIN, COORD_MIN);
        queue_load(3, COORD_MAX, COORD_MAX);
        queue_test(0, 0);
        queue_test(COORD_MIN, COORD_MAX);
        wait_drained();

        for (int p = 0; p < 12; p++)
        begin
            program_vertex_count(phase_counts[p]);
            eff  = (phase_counts[p] > VERTS) ? VERTS : phase_counts[p];
            mode = p % 4;
            send_idle_pct  = (mode == 1) ? 57 : (mode == 3) ? 10 : 0;
            recv_stall_pct = (mode == 2) ? 57 : (mode == 3) ? 10 : 0;
            long_hold_on   = (p == 4);
            make_polygon(eff, $urandom_range(0, 9) != 0);
            for (int k = 0; k < 31; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < 4)
                    make_polygon(eff, $urandom_range(0, 9) != 0);
                else if (r < 12)
                begin
                    // Nudge a vertex in use, or scribble on a spare slot.
                    slot = $urandom_range(0, VERTS - 1);
                    if (slot < eff)
                    begin
                        poly_x[slot] = clamp_coord(poly_x[slot] + spread(2));
                        poly_y[slot] = clamp_coord(poly_y[slot] + spread(2));
                        queue_load(slot, poly_x[slot], poly_y[slot]);
                    end
                    else
                        queue_load(slot, any_coord(), any_coord());
                end
                else
                    queue_probe(eff);
            end
            wait_drained();
            long_hold_on = 1'b0;
        end

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
